// ----- hdl/ascii_command_line_parser_assert.svh -----
// Assertion macros for the ascii command line parser.
// Needs clk and rst_n in the scope of each use.
`ifndef ASCII_COMMAND_LINE_PARSER_ASSERT_SVH
`define ASCII_COMMAND_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcp check failed");

// Next-cycle implication, checked outside reset
`define LCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcp check failed");

`endif

// ----- hdl/lcp_pkg.sv -----
// Shared types, codes and character helpers of the command line parser.
// No dependencies.
package lcp_pkg;

  localparam int LINE_BYTES = 32;
  localparam int PTR_W      = $clog2(LINE_BYTES);
  localparam int FRAC_DIGITS = 16;
  localparam int NFRAC_W    = $clog2(FRAC_DIGITS) + 1;

  // Result kinds
  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Command codes
  localparam logic [4:0] CMD_W      = 5'd8;
  localparam logic [4:0] CMD_O      = 5'd9;
  localparam logic [4:0] CMD_M      = 5'd10;
  localparam logic [4:0] CMD_CL_GET = 5'd11;
  localparam logic [4:0] CMD_CR_GET = 5'd14;
  localparam logic [4:0] CMD_SET_OFS  = 5'd1;
  localparam logic [4:0] CMD_TEST_OFS = 5'd2;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [31:0] Q_MINUS_ONE = 32'hFFFF_0000;
  localparam logic [16:0] IPART_MAX   = 17'h1_0000;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_EXEC  = 5'b00100,
    S_CONV  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Parse step that consumes the current byte
  typedef enum logic [8:0] {
    K_C0      = 9'b000000001,
    K_PLAIN   = 9'b000000010,
    K_SIDE    = 9'b000000100,
    K_LETTERS = 9'b000001000,
    K_PFIRST  = 9'b000010000,
    K_PBLANK  = 9'b000100000,
    K_PNUM    = 9'b001000000,
    K_PRES    = 9'b010000000,
    K_END     = 9'b100000000
  } step_t;

  // Control from the sequencer to the number unit
  typedef struct packed {
    logic       start;
    logic       neg;
    logic       lead_digit;
    logic       digit_en;
    logic       dot_en;
    logic       conv_go;
    logic [3:0] digit;
  } num_ctl_t;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // Single-letter commands a e f h r s p u map to 0..7; 8 means none
  function automatic logic [3:0] plain_index(input logic [7:0] c);
    case (c)
      8'h61: return 4'd0;
      8'h65: return 4'd1;
      8'h66: return 4'd2;
      8'h68: return 4'd3;
      8'h72: return 4'd4;
      8'h73: return 4'd5;
      8'h70: return 4'd6;
      8'h75: return 4'd7;
      default: return 4'd8;
    endcase
  endfunction

endpackage

// ----- hdl/lcp_line_store.sv -----
// Line store: one synchronous RAM, one write and one read port, registered read.
// Depends on lcp_pkg for depth and address width.
module lcp_line_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [lcp_pkg::PTR_W-1:0] wr_addr,
  input  logic [7:0]                wr_data,
  input  logic                      rd_en,
  input  logic [lcp_pkg::PTR_W-1:0] rd_addr,
  output logic [7:0]                rd_data
);

  logic [7:0] mem [lcp_pkg::LINE_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/lcp_fixconv.sv -----
// Number unit: gathers one decimal parameter and converts it to Q16.16.
// Fraction bits come from 16 doubling passes over the fraction digits.
// Depends on lcp_pkg.
module lcp_fixconv (
  input  logic              clk,
  input  logic              rst_n,
  input  lcp_pkg::num_ctl_t ctl,
  output logic              dots_bad,
  output logic              conv_done,
  output logic [31:0]       value
);

  logic                              neg_r;
  logic [16:0]                       ipart_r, ipart_nxt;
  logic [3:0]                        frac_r [lcp_pkg::FRAC_DIGITS];
  logic [3:0]                        frac_nxt [lcp_pkg::FRAC_DIGITS];
  logic [lcp_pkg::NFRAC_W-1:0]       nfrac_r;
  logic [1:0]                        dots_r;
  logic                              in_frac_r;
  logic [15:0]                       bits_r;
  logic                              run_r;
  logic [3:0]                        cnt_r;
  logic [20:0]                       ip10;
  logic [32:0]                       mag;

  // integer part times ten plus digit, saturated
  always_comb begin
    ip10 = {ipart_r, 3'b000} + {3'b000, ipart_r, 1'b0} + {17'd0, ctl.digit};
    ipart_nxt = (ip10 > {4'd0, lcp_pkg::IPART_MAX}) ? lcp_pkg::IPART_MAX : ip10[16:0];
  end

  // one doubling pass: each lane carries in from the next digit
  always_comb begin
    for (int i = 0; i < lcp_pkg::FRAC_DIGITS; i++) begin
      logic [3:0] dbl;
      logic       cin;
      dbl = (frac_r[i] >= 4'd5) ? 4'((frac_r[i] << 1) - 4'd10) : 4'(frac_r[i] << 1);
      cin = (i == lcp_pkg::FRAC_DIGITS - 1) ? 1'b0 : (frac_r[(i + 1) % lcp_pkg::FRAC_DIGITS] >= 4'd5);
      frac_nxt[i] = dbl + {3'b000, cin};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.conv_go) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 4'd1;
      if (cnt_r == 4'(lcp_pkg::FRAC_DIGITS - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // number payload
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg_r     <= ctl.neg;
      ipart_r   <= ctl.lead_digit ? {13'd0, ctl.digit} : '0;
      nfrac_r   <= '0;
      dots_r    <= '0;
      in_frac_r <= 1'b0;
      for (int i = 0; i < lcp_pkg::FRAC_DIGITS; i++) frac_r[i] <= '0;
    end else if (ctl.digit_en) begin
      if (!in_frac_r) begin
        ipart_r <= ipart_nxt;
      end else if (nfrac_r < lcp_pkg::NFRAC_W'(lcp_pkg::FRAC_DIGITS)) begin
        frac_r[nfrac_r[lcp_pkg::NFRAC_W-2:0]] <= ctl.digit;
        nfrac_r <= nfrac_r + 1'b1;
      end
    end else if (ctl.dot_en) begin
      in_frac_r <= 1'b1;
      if (dots_r != 2'd2) dots_r <= dots_r + 2'd1;
    end else if (run_r) begin
      for (int i = 0; i < lcp_pkg::FRAC_DIGITS; i++) frac_r[i] <= frac_nxt[i];
      bits_r <= {bits_r[14:0], frac_r[0] >= 4'd5};
    end
  end

  assign dots_bad  = (dots_r == 2'd2);
  assign conv_done = run_r && (cnt_r == 4'(lcp_pkg::FRAC_DIGITS - 1));

  // sign and saturation
  always_comb begin
    mag = {ipart_r, bits_r};
    if (neg_r) begin
      value = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - mag);
    end else begin
      value = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
  end

endmodule

// ----- hdl/ascii_command_line_parser.sv -----
// ASCII command line parser, top level: input handling, parse sequencer,
// result register. Uses lcp_pkg, lcp_line_store, lcp_fixconv and the assert header.
//
// Usage:
//   Input channel in_valid/in_ready/in_rx_byte carries raw received bytes.
//   Letters (upper case folded), digits, '-', '.', space and tab go into a
//   32-byte wrapping line store, one byte per cycle. Other bytes are dropped
//   with no result. CR or LF closes the line and gives exactly one request on
//   the result channel out_valid/out_ready with line kind, command code and
//   three Q16.16 values.
//   Flow: an empty line goes straight to the output step. A non-empty line
//   is parsed by a sequencer walking the store, a RAM read then a decode per
//   byte, plus per parameter 16 fraction doubling passes, the outcome step
//   and a second decode of the byte after the number, and a final step that
//   loads the result. in_ready is low while the parse runs or a result waits
//   to be loaded; stored bytes are taken back to back otherwise.
//   A finished result waits in the output register; new bytes are still
//   taken meanwhile, and the next line end parses and then waits until the
//   receiver has taken the earlier result.
//   Reset (rst_n low, synchronous) empties the line and the output register;
//   the store contents are not cleared and need not be.
`include "ascii_command_line_parser_assert.svh"
module ascii_command_line_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_line_kind,
  output logic [4:0]  out_command_code,
  output logic [31:0] out_first_value,
  output logic [31:0] out_second_value,
  output logic [31:0] out_third_value
);

  localparam logic [lcp_pkg::PTR_W-1:0] PTR_ONE = lcp_pkg::PTR_W'(1);

  lcp_pkg::state_t           state_r, state_nxt;
  lcp_pkg::step_t            step_r, step_nxt;
  logic [lcp_pkg::PTR_W-1:0] wp_r, wp_nxt;
  logic [lcp_pkg::PTR_W-1:0] cursor_r, cursor_nxt;
  logic [7:0]                c0_r, c0_nxt;
  logic                      side_r, side_nxt;
  logic [1:0]                pi_r, pi_nxt;
  logic                      pok_r, pok_nxt;
  logic [31:0]               v0_r, v0_nxt, v1_r, v1_nxt, v2_r, v2_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic [4:0]                code_r, code_nxt;
  logic                      out_valid_r;
  logic                      load;

  logic                      mem_we, mem_re;
  logic [7:0]                mem_wd, b;
  lcp_pkg::num_ctl_t         nctl;
  logic                      dots_bad, conv_done;
  logic [31:0]               conv_value;
  logic [3:0]                pidx;
  logic                      is_c, is_m;
  logic [4:0]                cbase;

  lcp_line_store u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wp_r),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (cursor_r),
    .rd_data (b)
  );

  lcp_fixconv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (nctl),
    .dots_bad  (dots_bad),
    .conv_done (conv_done),
    .value     (conv_value)
  );

  assign in_ready = (state_r == lcp_pkg::S_IDLE);
  assign pidx  = lcp_pkg::plain_index(b);
  assign is_c  = (c0_r == 8'h63);
  assign is_m  = (c0_r == 8'h6D);
  assign cbase = side_r ? lcp_pkg::CMD_CR_GET : lcp_pkg::CMD_CL_GET;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    wp_nxt     = wp_r;
    cursor_nxt = cursor_r;
    c0_nxt     = c0_r;
    side_nxt   = side_r;
    pi_nxt     = pi_r;
    pok_nxt    = pok_r;
    v0_nxt     = v0_r;
    v1_nxt     = v1_r;
    v2_nxt     = v2_r;
    kind_nxt   = kind_r;
    code_nxt   = code_r;
    mem_we     = 1'b0;
    mem_wd     = lcp_pkg::CH_NUL;
    mem_re     = 1'b0;
    load       = 1'b0;
    nctl       = '0;
    nctl.digit = b[3:0];

    case (state_r)
      lcp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (lcp_pkg::is_lower(in_rx_byte) || lcp_pkg::is_numeral(in_rx_byte) ||
              lcp_pkg::is_blank(in_rx_byte) || in_rx_byte == lcp_pkg::CH_MINUS ||
              in_rx_byte == lcp_pkg::CH_DOT || lcp_pkg::is_upper(in_rx_byte)) begin
            mem_we = 1'b1;
            mem_wd = lcp_pkg::is_upper(in_rx_byte) ? 8'(in_rx_byte + 8'd32) : in_rx_byte;
            wp_nxt = (wp_r == lcp_pkg::PTR_W'(lcp_pkg::LINE_BYTES - 1)) ? '0 : wp_r + 1'b1;
          end else if (in_rx_byte == lcp_pkg::CH_CR || in_rx_byte == lcp_pkg::CH_LF) begin
            mem_we   = 1'b1;
            code_nxt = '0;
            v0_nxt   = '0;
            v1_nxt   = '0;
            v2_nxt   = '0;
            if (wp_r == '0) begin
              kind_nxt  = lcp_pkg::KIND_EMPTY;
              state_nxt = lcp_pkg::S_OUT;
            end else begin
              wp_nxt     = '0;
              cursor_nxt = '0;
              step_nxt   = lcp_pkg::K_C0;
              state_nxt  = lcp_pkg::S_FETCH;
            end
          end
        end
      end

      lcp_pkg::S_FETCH: begin
        mem_re    = 1'b1;
        state_nxt = lcp_pkg::S_EXEC;
      end

      lcp_pkg::S_EXEC: begin
        case (step_r)
          // command letter
          lcp_pkg::K_C0: begin
            c0_nxt     = b;
            cursor_nxt = PTR_ONE;
            state_nxt  = lcp_pkg::S_FETCH;
            if (pidx != 4'd8) begin
              code_nxt = {1'b0, pidx};
              step_nxt = lcp_pkg::K_PLAIN;
            end else if (b == 8'h77 || b == 8'h6F || b == 8'h6D) begin
              code_nxt = (b == 8'h77) ? lcp_pkg::CMD_W :
                         (b == 8'h6F) ? lcp_pkg::CMD_O : lcp_pkg::CMD_M;
              step_nxt = lcp_pkg::K_LETTERS;
            end else if (b == 8'h63) begin
              step_nxt = lcp_pkg::K_SIDE;
            end else begin
              kind_nxt  = lcp_pkg::KIND_REJECT;
              state_nxt = lcp_pkg::S_OUT;
            end
          end
          lcp_pkg::K_PLAIN: begin
            kind_nxt  = (b == lcp_pkg::CH_NUL) ? lcp_pkg::KIND_ACCEPT : lcp_pkg::KIND_REJECT;
            state_nxt = lcp_pkg::S_OUT;
          end
          lcp_pkg::K_SIDE: begin
            if (b == 8'h6C || b == 8'h72) begin
              side_nxt   = (b == 8'h72);
              cursor_nxt = cursor_r + 1'b1;
              pi_nxt     = '0;
              step_nxt   = lcp_pkg::K_PFIRST;
              state_nxt  = lcp_pkg::S_FETCH;
            end else begin
              kind_nxt  = lcp_pkg::KIND_REJECT;
              state_nxt = lcp_pkg::S_OUT;
            end
          end
          lcp_pkg::K_LETTERS: begin
            if (lcp_pkg::is_lower(b)) begin
              cursor_nxt = cursor_r + 1'b1;
              state_nxt  = lcp_pkg::S_FETCH;
            end else begin
              pi_nxt   = '0;
              step_nxt = lcp_pkg::K_PFIRST;
            end
          end
          // a parameter must open with a blank
          lcp_pkg::K_PFIRST: begin
            if (lcp_pkg::is_blank(b)) begin
              cursor_nxt = cursor_r + 1'b1;
              step_nxt   = lcp_pkg::K_PBLANK;
              state_nxt  = lcp_pkg::S_FETCH;
            end else begin
              pok_nxt  = 1'b0;
              step_nxt = lcp_pkg::K_PRES;
            end
          end
          lcp_pkg::K_PBLANK: begin
            if (lcp_pkg::is_blank(b)) begin
              cursor_nxt = cursor_r + 1'b1;
              state_nxt  = lcp_pkg::S_FETCH;
            end else if (b == lcp_pkg::CH_MINUS || lcp_pkg::is_numeral(b)) begin
              nctl.start      = 1'b1;
              nctl.neg        = (b == lcp_pkg::CH_MINUS);
              nctl.lead_digit = lcp_pkg::is_numeral(b);
              cursor_nxt      = cursor_r + 1'b1;
              step_nxt        = lcp_pkg::K_PNUM;
              state_nxt       = lcp_pkg::S_FETCH;
            end else begin
              pok_nxt  = 1'b0;
              step_nxt = lcp_pkg::K_PRES;
            end
          end
          lcp_pkg::K_PNUM: begin
            if (lcp_pkg::is_numeral(b) || b == lcp_pkg::CH_DOT) begin
              nctl.digit_en = lcp_pkg::is_numeral(b);
              nctl.dot_en   = (b == lcp_pkg::CH_DOT);
              cursor_nxt    = cursor_r + 1'b1;
              state_nxt     = lcp_pkg::S_FETCH;
            end else if (dots_bad) begin
              pok_nxt  = 1'b0;
              step_nxt = lcp_pkg::K_PRES;
            end else begin
              nctl.conv_go = 1'b1;
              state_nxt    = lcp_pkg::S_CONV;
            end
          end
          // outcome of one parameter
          lcp_pkg::K_PRES: begin
            case (pi_r)
              2'd0: begin
                if (pok_r) begin
                  v0_nxt   = conv_value;
                  pi_nxt   = 2'd1;
                  step_nxt = lcp_pkg::K_PFIRST;
                end else if (is_c) begin
                  v0_nxt   = lcp_pkg::Q_MINUS_ONE;
                  step_nxt = lcp_pkg::K_END;
                end else begin
                  kind_nxt  = lcp_pkg::KIND_REJECT;
                  state_nxt = lcp_pkg::S_OUT;
                end
              end
              2'd1: begin
                if (pok_r) begin
                  v1_nxt = conv_value;
                  if (is_c || is_m) begin
                    pi_nxt   = 2'd2;
                    step_nxt = lcp_pkg::K_PFIRST;
                  end else begin
                    step_nxt = lcp_pkg::K_END;
                  end
                end else if (is_c) begin
                  v1_nxt   = lcp_pkg::Q_MINUS_ONE;
                  step_nxt = lcp_pkg::K_END;
                end else begin
                  kind_nxt  = lcp_pkg::KIND_REJECT;
                  state_nxt = lcp_pkg::S_OUT;
                end
              end
              2'd2: begin
                if (pok_r) begin
                  v2_nxt   = conv_value;
                  step_nxt = lcp_pkg::K_END;
                end else if (is_c) begin
                  kind_nxt  = lcp_pkg::KIND_REJECT;
                  state_nxt = lcp_pkg::S_OUT;
                end else begin
                  v2_nxt   = '0;
                  step_nxt = lcp_pkg::K_END;
                end
              end
              default: begin
                kind_nxt  = lcp_pkg::KIND_REJECT;
                state_nxt = lcp_pkg::S_OUT;
              end
            endcase
          end
          // line must end here
          lcp_pkg::K_END: begin
            state_nxt = lcp_pkg::S_OUT;
            if (b == lcp_pkg::CH_NUL) begin
              kind_nxt = lcp_pkg::KIND_ACCEPT;
              if (is_c) begin
                if (v1_r == lcp_pkg::Q_MINUS_ONE) code_nxt = cbase + lcp_pkg::CMD_TEST_OFS;
                else if (v0_r == lcp_pkg::Q_MINUS_ONE) code_nxt = cbase;
                else code_nxt = cbase + lcp_pkg::CMD_SET_OFS;
              end
            end else begin
              kind_nxt = lcp_pkg::KIND_REJECT;
            end
          end
          default: begin
            kind_nxt  = lcp_pkg::KIND_REJECT;
            state_nxt = lcp_pkg::S_OUT;
          end
        endcase
      end

      lcp_pkg::S_CONV: begin
        if (conv_done) begin
          pok_nxt   = 1'b1;
          step_nxt  = lcp_pkg::K_PRES;
          state_nxt = lcp_pkg::S_EXEC;
        end
      end

      lcp_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = lcp_pkg::S_IDLE;
        end
      end

      default: state_nxt = lcp_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcp_pkg::S_IDLE;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // parse payload
  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    cursor_r <= cursor_nxt;
    c0_r     <= c0_nxt;
    side_r   <= side_nxt;
    pi_r     <= pi_nxt;
    pok_r    <= pok_nxt;
    v0_r     <= v0_nxt;
    v1_r     <= v1_nxt;
    v2_r     <= v2_nxt;
    kind_r   <= kind_nxt;
    code_r   <= code_nxt;
  end

  // result register; non-accepted lines carry zero fields
  always_ff @(posedge clk) begin
    if (load) begin
      out_line_kind    <= kind_r;
      out_command_code <= (kind_r == lcp_pkg::KIND_ACCEPT) ? code_r : '0;
      out_first_value  <= (kind_r == lcp_pkg::KIND_ACCEPT) ? v0_r : '0;
      out_second_value <= (kind_r == lcp_pkg::KIND_ACCEPT) ? v1_r : '0;
      out_third_value  <= (kind_r == lcp_pkg::KIND_ACCEPT) ? v2_r : '0;
    end
  end

  assign out_valid = out_valid_r;

  `LCP_ASSERT_NEXT(a_parse_blocks_input,
    in_valid && in_ready && wp_r != '0 &&
    (in_rx_byte == lcp_pkg::CH_CR || in_rx_byte == lcp_pkg::CH_LF), !in_ready)
  `LCP_ASSERT_NOW(a_kind_legal, out_valid, out_line_kind != 2'd3)
  `LCP_ASSERT_NOW(a_code_range, out_valid, out_command_code <= 5'd16)
  `LCP_ASSERT_NOW(a_empty_fields,
    out_valid && out_line_kind != lcp_pkg::KIND_ACCEPT,
    out_command_code == '0 && out_first_value == '0 &&
    out_second_value == '0 && out_third_value == '0)
  `LCP_ASSERT_NOW(a_conv_in_conv, conv_done, state_r == lcp_pkg::S_CONV)

endmodule
